// ===== rtl/core/pift_pkg.sv =====
package pift_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  rule_id;
		logic [31:0] rule_priority;
		logic        rule_no_attach;
		logic [7:0]  class_value;
		logic [7:0]  subclass_value;
		logic [7:0]  protocol_value;
		logic [15:0] vendor_value;
		logic [15:0] product_value;
		logic [9:0]  match_modes;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [7:0]  matched_id;
		logic [31:0] matched_priority;
		logic        matched_no_attach;
	} response_t;

	// one stored rule, 107 bits
	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] priority_val;
		logic        skip_attach;
		logic [7:0]  class_value;
		logic [7:0]  subclass_value;
		logic [7:0]  protocol_value;
		logic [15:0] vendor_value;
		logic [15:0] product_value;
		logic [9:0]  modes;
	} rule_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic evaluate;
		logic apply;
	} dp_cmd_t;

endpackage

// ===== rtl/core/pift_ctrl.sv =====
module pift_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output pift_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_APPLY);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign cmd.capture  = (state_q == S_IDLE) && start;
	assign cmd.evaluate = (state_q == S_EVAL);
	assign cmd.apply    = (state_q == S_APPLY);

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_APPLY))
		else $error("result strobe without a preceding apply step");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> busy)
		else $error("block not busy after taking a transaction");

endmodule

// ===== rtl/core/pift_dp.sv =====
module pift_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pift_pkg::dp_cmd_t   cmd,
	input  pift_pkg::request_t  request,
	output pift_pkg::response_t response
);

	localparam logic [1:0] MODE_EQ = 2'd1;
	localparam logic [1:0] MODE_NE = 2'd2;

	pift_pkg::request_t  req_q;
	pift_pkg::response_t response_q;
	pift_pkg::rule_t     entries_q [pift_pkg::TABLE_DEPTH];
	logic [pift_pkg::CNT_W-1:0] count_q;

	logic                       dup_s2;
	logic                       hit_s2;
	logic [pift_pkg::CNT_W-1:0] pos_s2;
	logic [pift_pkg::IDX_W-1:0] hit_idx_s2;

	logic [pift_pkg::TABLE_DEPTH-1:0] dup_vec;
	logic [pift_pkg::TABLE_DEPTH-1:0] le_vec;
	logic [pift_pkg::TABLE_DEPTH-1:0] match_vec;
	logic [pift_pkg::CNT_W-1:0]       pos_c;
	logic [pift_pkg::IDX_W-1:0]       hit_idx_c;
	pift_pkg::rule_t                  new_rule;
	pift_pkg::rule_t                  hit_rule;
	pift_pkg::response_t              response_c;

	function automatic logic field_ok(input logic [1:0] mode, input logic eq);
		logic ok;
		case (mode)
			MODE_EQ: ok = eq;
			MODE_NE: ok = !eq;
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

	function automatic logic rule_match(input pift_pkg::rule_t r,
		input pift_pkg::request_t d);
		logic ok;
		ok = field_ok(r.modes[1:0], r.class_value == d.class_value)
			&& field_ok(r.modes[3:2], r.subclass_value == d.subclass_value)
			&& field_ok(r.modes[5:4], r.protocol_value == d.protocol_value)
			&& field_ok(r.modes[7:6], r.vendor_value == d.vendor_value)
			&& field_ok(r.modes[9:8], r.product_value == d.product_value);
		return ok;
	endfunction

	// per-entry compares, all entries side by side
	always_comb begin
		for (int i = 0; i < pift_pkg::TABLE_DEPTH; i++) begin
			dup_vec[i]   = (pift_pkg::CNT_W'(i) < count_q)
				&& (entries_q[i].id == req_q.rule_id);
			le_vec[i]    = (pift_pkg::CNT_W'(i) < count_q)
				&& (req_q.rule_priority <= entries_q[i].priority_val);
			match_vec[i] = (pift_pkg::CNT_W'(i) < count_q)
				&& rule_match(entries_q[i], req_q);
		end
	end

	// first set bit wins
	always_comb begin
		pos_c     = count_q;
		hit_idx_c = '0;
		for (int i = pift_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
			if (le_vec[i]) begin
				pos_c = pift_pkg::CNT_W'(i);
			end
			if (match_vec[i]) begin
				hit_idx_c = pift_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		new_rule.id             = req_q.rule_id;
		new_rule.priority_val   = req_q.rule_priority;
		new_rule.skip_attach    = req_q.rule_no_attach;
		new_rule.class_value    = req_q.class_value;
		new_rule.subclass_value = req_q.subclass_value;
		new_rule.protocol_value = req_q.protocol_value;
		new_rule.vendor_value   = req_q.vendor_value;
		new_rule.product_value  = req_q.product_value;
		new_rule.modes          = req_q.match_modes;
	end

	assign hit_rule = entries_q[hit_idx_s2];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.evaluate) begin
			dup_s2     <= |dup_vec;
			hit_s2     <= |match_vec;
			pos_s2     <= pos_c;
			hit_idx_s2 <= hit_idx_c;
		end
	end

	// table write: open a slot at the insert position and shift the tail up
	always_ff @(posedge clk) begin
		if (cmd.apply && (req_q.operation == pift_pkg::OP_INSERT) && !dup_s2
			&& (count_q != pift_pkg::CNT_W'(pift_pkg::TABLE_DEPTH))) begin
			for (int i = 1; i < pift_pkg::TABLE_DEPTH; i++) begin
				if ((pift_pkg::CNT_W'(i) > pos_s2) && (pift_pkg::CNT_W'(i) <= count_q)) begin
					entries_q[i] <= entries_q[i-1];
				end
			end
			for (int i = 0; i < pift_pkg::TABLE_DEPTH; i++) begin
				if (pift_pkg::CNT_W'(i) == pos_s2) begin
					entries_q[i] <= new_rule;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			case (req_q.operation)
				pift_pkg::OP_INSERT: begin
					if (!dup_s2 && (count_q != pift_pkg::CNT_W'(pift_pkg::TABLE_DEPTH))) begin
						count_q <= count_q + 1'b1;
					end
				end
				pift_pkg::OP_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// result of the step being applied; fields not named stay zero
	always_comb begin
		response_c = '0;
		case (req_q.operation)
			pift_pkg::OP_INSERT: begin
				if (dup_s2) begin
					response_c.status = pift_pkg::ST_DUP;
				end else if (count_q == pift_pkg::CNT_W'(pift_pkg::TABLE_DEPTH)) begin
					response_c.status = pift_pkg::ST_FULL;
				end else begin
					response_c.status = pift_pkg::ST_DONE;
				end
			end
			pift_pkg::OP_LOOKUP: begin
				if (hit_s2) begin
					response_c.hit               = 1'b1;
					response_c.matched_id        = hit_rule.id;
					response_c.matched_priority  = hit_rule.priority_val;
					response_c.matched_no_attach = hit_rule.skip_attach;
				end
			end
			default: begin
				response_c.status = pift_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			response_q <= response_c;
		end
	end

	assign response = response_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pift_pkg::CNT_W'(pift_pkg::TABLE_DEPTH))
		else $error("rule count above table depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && (req_q.operation == pift_pkg::OP_CLEAR) |=> count_q == '0)
		else $error("clear did not empty the table");

	a_count_only_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.apply |=> $stable(count_q))
		else $error("rule count changed outside the apply step");

endmodule

// ===== rtl/core/priority_interface_filter_table.sv =====
// A transaction accepted on start is captured, evaluated and applied in turn; done is
// strobed in the cycle after the apply step, and the receiver takes the result then.
// A new transaction is not taken during the evaluate and apply steps of the
// controller; busy is high during those steps. The receiver cannot stall.
// Reset: arst_n clears the controller and the rule count; the table is empty after reset.
module priority_interface_filter_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pift_pkg::request_t  request,
	output logic                done,
	output pift_pkg::response_t response
);

	pift_pkg::dp_cmd_t cmd;

	// Controller: sequence one transaction through capture, evaluate, apply and
	// pulse done for exactly one cycle once the result register is loaded.
	pift_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath: the rule table held in priority order, compared against the
	// captured request in all rows at once.
	// Evaluate registers the duplicate flag, the insert slot and the first hit;
	// apply shifts the tail of the table up and writes the new rule on an insert,
	// empties the table on a clear, and loads the result register. The result holds
	// until the next apply, so a new start may be taken in the same cycle that done is high.
	pift_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.request  (request),
		.response (response)
	);

endmodule
